@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, masked during reset
`define PSE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// clocked check that also holds during reset
`define PSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSE_ASSERT(lbl, clk, rstn, prop, msg)
`define PSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/pse_pkg.sv @@
// shared constants, codes and controller/datapath signal groups
// for the postfix stack evaluator; no dependencies
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned STEPS       = DATA_W;
  localparam int unsigned STEP_W      = $clog2(STEPS);

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_PUSH  = 3'd0;
  localparam opcode_t OP_ADD   = 3'd1;
  localparam opcode_t OP_SUB   = 3'd2;
  localparam opcode_t OP_MUL   = 3'd3;
  localparam opcode_t OP_DIV   = 3'd4;
  localparam opcode_t OP_POW   = 3'd5;
  localparam opcode_t OP_RSVD6 = 3'd6;
  localparam opcode_t OP_RSVD7 = 3'd7;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DIVZERO = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_BADOP   = 3'd4
  } status_e;

  typedef struct packed {
    logic load_tok;
    logic rd_second;
    logic load_ops;
    logic exec;
    logic div_step;
    logic pow_step;
    logic fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_fetch;
    logic div_iter;
    logic pow_iter;
    logic out_free;
  } stat_t;

endpackage

@@ src/pse_if.sv @@
// valid/ready channel interfaces for token requests and results
// depends on pse_pkg for widths
interface pse_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  digit;
  logic        last_token;

  modport source (output valid, output opcode, output digit, output last_token, input ready);
  modport sink   (input valid, input opcode, input digit, input last_token, output ready);
endinterface

interface pse_res_if;
  logic                            valid;
  logic                            ready;
  logic signed [pse_pkg::DATA_W-1:0] top_value;
  logic [2:0]                      status;
  logic                            done_res;

  modport source (output valid, output top_value, output status, output done_res, input ready);
  modport sink   (input valid, input top_value, input status, input done_res, output ready);
endinterface

@@ src/pse_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module pse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pse_ctrl.sv @@
// controller state machine: sequences decode, operand fetch, execution,
// iterative steps and commit; depends on pse_pkg
module pse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pse_pkg::stat_t stat_i,
  output pse_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_EXEC,
    S_DIV,
    S_POW,
    S_FIX,
    S_COMMIT
  } state_e;

  state_e                      state_q, state_d;
  logic [pse_pkg::STEP_W-1:0]  step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_tok = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.need_fetch) begin
          cmd_o.rd_second = 1'b1;
          state_d         = S_FETCH;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_FETCH: begin
        cmd_o.load_ops = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        step_d     = '0;
        if (stat_i.div_iter) begin
          state_d = S_DIV;
        end else if (stat_i.pow_iter) begin
          state_d = S_POW;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == pse_pkg::STEP_W'(pse_pkg::STEPS - 1)) begin
          state_d = S_FIX;
        end
      end
      S_POW: begin
        cmd_o.pow_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == pse_pkg::STEP_W'(pse_pkg::STEPS - 1)) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ src/pse_dp.sv @@
// datapath: token and stack registers, operand store, alu, restoring
// divider, square-and-multiply power and result register; depends on pse_pkg, pse_ram
module pse_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pse_pkg::cmd_t                     cmd_i,
  output pse_pkg::stat_t                    stat_o,
  input  logic [2:0]                        opcode_i,
  input  logic [3:0]                        digit_i,
  input  logic                              last_token_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [pse_pkg::DATA_W-1:0] top_value_o,
  output logic [2:0]                        status_o,
  output logic                              done_res_o
);

  localparam int unsigned DW = pse_pkg::DATA_W;
  localparam int unsigned LW = pse_pkg::LVL_W;
  localparam int unsigned AW = pse_pkg::ADDR_W;

  // token
  pse_pkg::opcode_t op_q;
  logic [3:0]       dig_q;
  logic             last_q;

  // architectural state
  logic [DW-1:0]    top_q;
  logic [LW-1:0]    level_q;
  pse_pkg::status_e err_q;

  // operands and result
  logic [DW-1:0]    lhs_q, rhs_q, res_q;
  logic             fail_q;

  // divider and power registers
  logic [DW-1:0]    quo_q, rem_q, dvs_q;
  logic             neg_q;
  logic [DW-1:0]    acc_q, base_q, exp_q;

  // output register
  logic                  out_valid_q;
  logic signed [DW-1:0]  out_top_q;
  pse_pkg::status_e      out_st_q;
  logic                  out_done_q;

  logic [DW-1:0] rd_data;
  logic [LW-1:0] lvl_m1, lvl_m2;
  logic          op_binary;

  assign lvl_m1    = level_q - LW'(1);
  assign lvl_m2    = level_q - LW'(2);
  assign op_binary = (op_q == pse_pkg::OP_ADD) || (op_q == pse_pkg::OP_SUB) ||
                     (op_q == pse_pkg::OP_MUL) || (op_q == pse_pkg::OP_DIV) ||
                     (op_q == pse_pkg::OP_POW);

  assign stat_o.need_fetch = (err_q == pse_pkg::ST_OK) && op_binary && (level_q >= LW'(2));
  assign stat_o.div_iter   = (op_q == pse_pkg::OP_DIV) && (rhs_q != '0);
  assign stat_o.pow_iter   = (op_q == pse_pkg::OP_POW) && !rhs_q[DW-1];
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // commit decision
  logic [DW-1:0]    nxt_top;
  logic [LW-1:0]    nxt_level;
  pse_pkg::status_e nxt_err;
  logic             push_we;

  always_comb begin
    nxt_top   = top_q;
    nxt_level = level_q;
    nxt_err   = err_q;
    push_we   = 1'b0;
    if (err_q == pse_pkg::ST_OK) begin
      case (op_q)
        pse_pkg::OP_PUSH: begin
          if (level_q == LW'(pse_pkg::STACK_DEPTH)) begin
            nxt_err = pse_pkg::ST_OVER;
          end else begin
            push_we   = (level_q != '0);
            nxt_top   = DW'(dig_q);
            nxt_level = level_q + LW'(1);
          end
        end
        pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL,
        pse_pkg::OP_DIV, pse_pkg::OP_POW: begin
          if (level_q < LW'(2)) begin
            nxt_err = pse_pkg::ST_UNDER;
          end else if (fail_q) begin
            nxt_err = pse_pkg::ST_DIVZERO;
          end else begin
            nxt_top   = res_q;
            nxt_level = lvl_m1;
          end
        end
        default: begin
          nxt_err = pse_pkg::ST_BADOP;
        end
      endcase
    end
  end

  pse_ram #(
    .WIDTH (DW),
    .DEPTH (pse_pkg::STACK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && push_we),
    .waddr_i (lvl_m1[AW-1:0]),
    .wdata_i (top_q),
    .re_i    (cmd_i.rd_second),
    .raddr_i (lvl_m2[AW-1:0]),
    .rdata_o (rd_data)
  );

  // divider step
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_diff;
  assign rem_sh   = {rem_q, quo_q[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      op_q   <= opcode_i;
      dig_q  <= digit_i;
      last_q <= last_token_i;
    end
    if (cmd_i.load_ops) begin
      lhs_q <= rd_data;
      rhs_q <= top_q;
    end
    if (cmd_i.exec) begin
      fail_q <= 1'b0;
      case (op_q)
        pse_pkg::OP_ADD: res_q <= lhs_q + rhs_q;
        pse_pkg::OP_SUB: res_q <= lhs_q - rhs_q;
        pse_pkg::OP_MUL: res_q <= lhs_q * rhs_q;
        pse_pkg::OP_DIV: begin
          fail_q <= (rhs_q == '0);
          neg_q  <= lhs_q[DW-1] ^ rhs_q[DW-1];
          quo_q  <= lhs_q[DW-1] ? (DW'(0) - lhs_q) : lhs_q;
          dvs_q  <= rhs_q[DW-1] ? (DW'(0) - rhs_q) : rhs_q;
          rem_q  <= '0;
        end
        pse_pkg::OP_POW: begin
          if (rhs_q[DW-1]) begin
            // negative exponent
            if (lhs_q == '0) begin
              fail_q <= 1'b1;
            end else if (lhs_q == DW'(1)) begin
              res_q <= DW'(1);
            end else if (lhs_q == '1) begin
              res_q <= rhs_q[0] ? '1 : DW'(1);
            end else begin
              res_q <= '0;
            end
          end else begin
            acc_q  <= DW'(1);
            base_q <= lhs_q;
            exp_q  <= rhs_q;
          end
        end
        default: res_q <= res_q;
      endcase
    end
    if (cmd_i.div_step) begin
      if (!rem_diff[DW]) begin
        rem_q <= rem_diff[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.pow_step) begin
      if (exp_q[0]) begin
        acc_q <= acc_q * base_q;
      end
      base_q <= base_q * base_q;
      exp_q  <= exp_q >> 1;
    end
    if (cmd_i.fix) begin
      if (op_q == pse_pkg::OP_DIV) begin
        res_q <= neg_q ? (DW'(0) - quo_q) : quo_q;
      end else begin
        res_q <= acc_q;
      end
    end
    if (cmd_i.commit) begin
      top_q      <= nxt_top;
      out_top_q  <= ((nxt_err == pse_pkg::ST_OK) && (nxt_level != '0)) ? nxt_top : '0;
      out_st_q   <= nxt_err;
      out_done_q <= last_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      err_q       <= pse_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          level_q <= '0;
          err_q   <= pse_pkg::ST_OK;
        end else begin
          level_q <= nxt_level;
          err_q   <= nxt_err;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign status_o    = out_st_q;
  assign done_res_o  = out_done_q;

endmodule

@@ src/postfix_stack_evaluator.sv @@
// top level of the postfix stack evaluator: controller, datapath, checks
// depends on pse_pkg, pse_if, pse_ram, pse_ctrl, pse_dp, assert_macros.svh
//
// Evaluates a postfix token stream one token at a time, with exactly one result per
// token. A digit pushes its 4-bit value; add, subtract, multiply, divide and power pop
// two values and push the 32-bit wrapped result. The first error is held until the
// token marked last, whose result closes the expression and empties the stack. The
// stack top lives in a register and the rest in a 64-entry ram with registered read,
// so an operator costs one ram read. Tokens are handled one at a time, and the count of
// states a token passes through depends on its kind: a push, an invalid opcode, an
// operator with fewer than two values stacked or any token under a held error goes from
// decode to commit; add, subtract, multiply, a divide by zero and a power with a
// negative exponent pass through fetch and execute; any other divide or power also runs
// the 32 one-bit steps of the restoring divider or of the square-and-multiply loop. A new
// token is taken while the previous result still waits in the output register, but the
// next result is written only once that register is free, so a stalled receiver adds its
// wait to these counts. No clearing pass is needed after reset.
`include "assert_macros.svh"

module postfix_stack_evaluator (
  input logic       clk_i,
  input logic       rst_ni,
  pse_tok_if.sink   tok_i,
  pse_res_if.source res_o
);

  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t stat;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tok_i.valid),
    .in_ready_o (tok_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pse_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (tok_i.opcode),
    .digit_i      (tok_i.digit),
    .last_token_i (tok_i.last_token),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .top_value_o  (res_o.top_value),
    .status_o     (res_o.status),
    .done_res_o   (res_o.done_res)
  );

  `PSE_ASSERT(a_commit_free, clk_i, rst_ni, cmd.commit |-> stat.out_free, "commit into a busy output register")
  `PSE_ASSERT(a_valid_from_commit, clk_i, rst_ni, $rose(res_o.valid) |-> $past(cmd.commit), "result without commit")
  `PSE_ASSERT(a_err_zero_top, clk_i, rst_ni, (res_o.valid && (res_o.status != pse_pkg::ST_OK)) |-> (res_o.top_value == 0), "error result with nonzero top")
  `PSE_ASSERT(a_no_accept_busy, clk_i, rst_ni, cmd.load_tok |=> !tok_i.ready, "request taken while a token is in flight")

endmodule

@@ tb/sv/postfix_stack_evaluator_tb.sv @@
`timescale 1ns / 1ps
// testbench for postfix_stack_evaluator: directed and random token streams with
// random gaps and back-pressure, each result checked against an in-bench predictor
// depends on pse_pkg, pse_if and the rtl of the evaluator
module postfix_stack_evaluator_tb;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_TOKENS  = 580;
  localparam int unsigned HOLD_CYCLES    = 200;

  typedef struct {
    logic signed [pse_pkg::DATA_W-1:0] top_value;
    pse_pkg::status_e                  status;
    logic                              done_res;
  } result_t;

  logic clk;
  logic rst_n;

  pse_tok_if tok_if ();
  pse_res_if res_if ();

  postfix_stack_evaluator DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .tok_i  (tok_if),
    .res_o  (res_if)
  );

  logic [pse_pkg::DATA_W-1:0] operand_stack [pse_pkg::STACK_DEPTH];
  int unsigned                stack_level = 0;
  pse_pkg::status_e           held_status = pse_pkg::ST_OK;

  result_t     predicted_results [$];
  int unsigned mismatches     = 0;
  int unsigned tokens_sent    = 0;
  int unsigned hold_len       = 0;
  bit          sender_burst   = 0;
  bit          receiver_burst = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void evaluate_token(pse_pkg::opcode_t op, logic [3:0] dig, logic last);
    logic [pse_pkg::DATA_W-1:0] lhs, rhs, val, ma, mb, acc, b, e;
    bit                         ok;
    result_t                    r;
    ok  = 1'b1;
    val = '0;
    if (held_status == pse_pkg::ST_OK) begin
      if (op == pse_pkg::OP_PUSH) begin
        if (stack_level >= pse_pkg::STACK_DEPTH) begin
          held_status = pse_pkg::ST_OVER;
        end else begin
          operand_stack[stack_level] = {28'd0, dig};
          stack_level++;
        end
      end else if (op > pse_pkg::OP_POW) begin
        held_status = pse_pkg::ST_BADOP;
      end else if (stack_level < 2) begin
        held_status = pse_pkg::ST_UNDER;
      end else begin
        rhs = operand_stack[stack_level-1];
        lhs = operand_stack[stack_level-2];
        case (op)
          pse_pkg::OP_ADD: val = lhs + rhs;
          pse_pkg::OP_SUB: val = lhs - rhs;
          pse_pkg::OP_MUL: val = lhs * rhs;
          pse_pkg::OP_DIV: begin
            if (rhs == '0) begin
              ok = 1'b0;
            end else begin
              ma  = lhs[pse_pkg::DATA_W-1] ? ('0 - lhs) : lhs;
              mb  = rhs[pse_pkg::DATA_W-1] ? ('0 - rhs) : rhs;
              val = ma / mb;
              if (lhs[pse_pkg::DATA_W-1] ^ rhs[pse_pkg::DATA_W-1]) val = '0 - val;
            end
          end
          default: begin
            if (rhs[pse_pkg::DATA_W-1]) begin
              if (lhs == '0) ok = 1'b0;
              else if (lhs == 1) val = 1;
              else if (lhs == '1) val = rhs[0] ? '1 : 1;
              else val = '0;
            end else begin
              acc = 1;
              b   = lhs;
              e   = rhs;
              while (e != '0) begin
                if (e[0]) acc = acc * b;
                b = b * b;
                e = e >> 1;
              end
              val = acc;
            end
          end
        endcase
        if (!ok) begin
          held_status = pse_pkg::ST_DIVZERO;
        end else begin
          stack_level--;
          operand_stack[stack_level-1] = val;
        end
      end
    end
    r.top_value = (held_status == pse_pkg::ST_OK && stack_level > 0) ?
                  operand_stack[stack_level-1] : '0;
    r.status    = held_status;
    r.done_res  = last;
    predicted_results.push_back(r);
    if (last) begin
      stack_level = 0;
      held_status = pse_pkg::ST_OK;
    end
  endfunction

  task automatic send_token(input pse_pkg::opcode_t op, input logic [3:0] dig,
                            input logic last);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      tok_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tok_if.valid      <= 1'b1;
    tok_if.opcode     <= op;
    tok_if.digit      <= dig;
    tok_if.last_token <= last;
    do @(posedge clk); while (!tok_if.ready);
    evaluate_token(op, dig, last);
    tokens_sent++;
  endtask

  task automatic wait_for_results();
    tok_if.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_operators();
    send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd15, 1'b0);
    send_token(pse_pkg::OP_ADD, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd9, 1'b0);
    send_token(pse_pkg::OP_SUB, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd7, 1'b0);
    send_token(pse_pkg::OP_MUL, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd2, 1'b0);
    send_token(pse_pkg::OP_DIV, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd3, 1'b0);
    send_token(pse_pkg::OP_POW, 4'd0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_errors();
    // divide by zero, then tokens under the held error
    send_token(pse_pkg::OP_PUSH, 4'd5, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
    send_token(pse_pkg::OP_DIV, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd1, 1'b0);
    send_token(pse_pkg::OP_RSVD6, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd2, 1'b1);
    // underflow on empty and on one value
    send_token(pse_pkg::OP_ADD, 4'd0, 1'b1);
    send_token(pse_pkg::OP_PUSH, 4'd1, 1'b0);
    send_token(pse_pkg::OP_POW, 4'd0, 1'b1);
    // invalid opcodes
    send_token(pse_pkg::OP_RSVD7, 4'd0, 1'b1);
    send_token(pse_pkg::OP_RSVD6, 4'd15, 1'b1);
    wait_for_results();
  endtask

  task automatic test_special_values();
    // 2^31 divided by -1 wraps
    send_token(pse_pkg::OP_PUSH, 4'd2, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd15, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd15, 1'b0);
    send_token(pse_pkg::OP_ADD, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd1, 1'b0);
    send_token(pse_pkg::OP_ADD, 4'd0, 1'b0);
    send_token(pse_pkg::OP_POW, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd1, 1'b0);
    send_token(pse_pkg::OP_SUB, 4'd0, 1'b0);
    send_token(pse_pkg::OP_DIV, 4'd0, 1'b1);
    // zero to the zero
    send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
    send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
    send_token(pse_pkg::OP_POW, 4'd0, 1'b1);
    // negative exponents on bases 1, -1, 2 and 0
    for (int base_sel = 0; base_sel < 5; base_sel++) begin
      if (base_sel == 1 || base_sel == 2) begin
        send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
        send_token(pse_pkg::OP_PUSH, 4'd1, 1'b0);
        send_token(pse_pkg::OP_SUB, 4'd0, 1'b0);
      end else begin
        send_token(pse_pkg::OP_PUSH,
                   (base_sel == 0) ? 4'd1 : (base_sel == 3) ? 4'd2 : 4'd0, 1'b0);
      end
      send_token(pse_pkg::OP_PUSH, 4'd0, 1'b0);
      send_token(pse_pkg::OP_PUSH, (base_sel == 2) ? 4'd2 : 4'd1, 1'b0);
      send_token(pse_pkg::OP_SUB, 4'd0, 1'b0);
      send_token(pse_pkg::OP_POW, 4'd0, 1'b1);
    end
    wait_for_results();
  endtask

  task automatic test_full_stack();
    sender_burst = 1'b1;
    for (int i = 0; i < pse_pkg::STACK_DEPTH; i++) send_token(pse_pkg::OP_PUSH, 4'd15, 1'b0);
    for (int i = 0; i < pse_pkg::STACK_DEPTH - 1; i++) begin
      send_token(pse_pkg::OP_ADD, 4'd0, i == pse_pkg::STACK_DEPTH - 2);
    end
    sender_burst = 1'b0;
    for (int i = 0; i <= pse_pkg::STACK_DEPTH; i++) send_token(pse_pkg::OP_PUSH, 4'(i), 1'b0);
    send_token(pse_pkg::OP_ADD, 4'd0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    hold_len     = HOLD_CYCLES;
    sender_burst = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_token((i % 3 == 2) ? pse_pkg::OP_MUL : pse_pkg::OP_PUSH,
                 4'($urandom_range(0, 15)), i == 11);
    end
    sender_burst = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_expressions();
    int unsigned start, pick, k, pushes_left, ops_left, depth, len;
    bit          deep, is_op;
    start = tokens_sent;
    while (tokens_sent - start < RANDOM_TOKENS) begin
      sender_burst   = ($urandom_range(0, 4) == 0);
      receiver_burst = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 4) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_token(pse_pkg::opcode_t'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     (i == len - 1) || ($urandom_range(0, 9) == 0));
        end
      end else begin
        deep        = (pick == 4);
        k           = deep ? $urandom_range(40, 70) : $urandom_range(0, 10);
        pushes_left = k + 1;
        ops_left    = k;
        depth       = 0;
        while (pushes_left + ops_left > 0) begin
          is_op = depth >= 2 && ops_left > 0 &&
                  (pushes_left == 0 || (!deep && $urandom_range(0, 1) == 1));
          if (is_op) begin
            ops_left--;
            depth--;
            send_token(pse_pkg::opcode_t'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_POW)),
                       4'($urandom_range(0, 15)), pushes_left + ops_left == 0);
          end else begin
            pushes_left--;
            depth++;
            send_token(pse_pkg::OP_PUSH, 4'($urandom_range(0, 15)),
                       pushes_left + ops_left == 0);
          end
        end
      end
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    wait_for_results();
  endtask

  // result sink with random stalls and checking
  initial begin
    int unsigned stall;
    result_t     exp_res;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        stall = receiver_burst ? 0 : $urandom_range(0, 7);
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      if (predicted_results.size() == 0) begin
        $error("result with no request pending: top_value %0d", res_if.top_value);
        mismatches++;
      end else begin
        exp_res = predicted_results.pop_front();
        if (res_if.top_value !== exp_res.top_value) begin
          $error("top_value: expected %0d, actual %0d", exp_res.top_value, res_if.top_value);
          mismatches++;
        end
        if (res_if.status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, res_if.status);
          mismatches++;
        end
        if (res_if.done_res !== exp_res.done_res) begin
          $error("done_res: expected %0d, actual %0d", exp_res.done_res, res_if.done_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    tok_if.valid      <= 1'b0;
    tok_if.opcode     <= pse_pkg::OP_PUSH;
    tok_if.digit      <= 4'd0;
    tok_if.last_token <= 1'b0;
    rst_n             <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_operators();
    test_errors();
    test_special_values();
    test_full_stack();
    test_backpressure();
    test_random_expressions();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/pse_pkg.sv
src/pse_if.sv
src/pse_ram.sv
src/pse_ctrl.sv
src/pse_dp.sv
src/postfix_stack_evaluator.sv
tb/sv/postfix_stack_evaluator_tb.sv
